// ----- rtl/core/nsq_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the fixed-point Newton square root core.
// Used by every other file in the project; depends on nothing.
package nsq_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned ROOT_W = 31;
  localparam int unsigned FRAC_W = 24;

  // Quotient bits produced by the divider and width of its divisor and remainder.
  localparam int unsigned QUO_W = 26;
  localparam int unsigned DVS_W = 27;

  localparam int unsigned CONST_W = FRAC_W;
  localparam logic [CONST_W-1:0] SEED_A    = CONST_W'(7001300);
  localparam logic [CONST_W-1:0] SEED_B    = CONST_W'(9901241);
  localparam logic [CONST_W-1:0] INV_SQRT2 = CONST_W'(11863283);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/core/nsq_div.sv -----
`timescale 1ns / 1ps
// Bit-serial restoring divider computing (mant << FRAC_W) / divisor.
// Depends on nsq_pkg for widths and the status struct.
module nsq_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [nsq_pkg::FRAC_W-1:0]  mant_i,
  input  logic [nsq_pkg::DVS_W-1:0]   divisor_i,
  output nsq_pkg::div_stat_t          stat_o,
  output logic [nsq_pkg::QUO_W-1:0]   quo_o
);

  localparam int unsigned PRE_W = nsq_pkg::QUO_W - nsq_pkg::FRAC_W;
  localparam int unsigned CNT_W = $clog2(nsq_pkg::QUO_W);
  localparam int unsigned SH_W  = nsq_pkg::QUO_W;
  localparam int unsigned DW    = nsq_pkg::DVS_W;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0]    dvs_q, dvs_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [SH_W-1:0]  sh_q, sh_d;
  logic [nsq_pkg::QUO_W-1:0] quo_q, quo_d;
  logic [DW:0]      shifted;
  logic [DW:0]      trial;

  // The quotient is known to fit QUO_W bits, so the top dividend bits seed the
  // remainder directly and only QUO_W steps remain.
  assign shifted = {rem_q, sh_q[SH_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(nsq_pkg::QUO_W - 1);
      dvs_d  = divisor_i;
      rem_d  = DW'(mant_i[nsq_pkg::FRAC_W-1:PRE_W]);
      sh_d   = {mant_i[PRE_W-1:0], {nsq_pkg::FRAC_W{1'b0}}};
      quo_d  = '0;
    end else if (busy_q) begin
      if (!trial[DW]) begin
        rem_d = trial[DW-1:0];
      end else begin
        rem_d = shifted[DW-1:0];
      end
      quo_d = {quo_q[nsq_pkg::QUO_W-2:0], ~trial[DW]};
      sh_d  = {sh_q[SH_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    sh_q  <= sh_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule

// ----- rtl/core/fixed_point_newton_sqrt_core.sv -----
`timescale 1ns / 1ps
// Fixed-point square root: one-bit normalizer, linear seed, two Newton steps.
// Depends on nsq_pkg and instantiates nsq_div.
//
// Usage:
//   The input channel (in_valid_i, in_ready_o, operand_i) takes a signed value
//   with 24 fraction bits. The output channel (out_valid_o, out_ready_i,
//   root_o) returns its square root in the same format; zero and negative
//   requests give 0. Every request gives exactly one result, in order.
//   in_ready_o is high only while the core is idle; one request is worked on
//   at a time. For a positive value the normalizer first moves the leading
//   one to bit 23, one bit per cycle; then the shared divider, run twice,
//   retires one quotient bit per cycle (26 bits per division, plus its start
//   and handoff steps), and the result is registered after the final scaling.
//   Zero and negative values go straight to the final step. The next request
//   is accepted in the cycle after the result is registered.
//   The result sits in an output register; a new request is accepted while it
//   waits. If the receiver stalls, the core holds its next result in the last
//   step until the output register frees. Reset empties the output register
//   and returns the core to idle.
module fixed_point_newton_sqrt_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [nsq_pkg::WORD_W-1:0] operand_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [nsq_pkg::ROOT_W-1:0]        root_o
);

  localparam int unsigned FW  = nsq_pkg::FRAC_W;
  localparam int unsigned DW  = nsq_pkg::DVS_W;
  localparam int unsigned WW  = nsq_pkg::WORD_W;
  localparam int unsigned RW  = nsq_pkg::ROOT_W;
  localparam int unsigned PW  = nsq_pkg::CONST_W + DW;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_NORM    = 9'b000000010,
    ST_SEED    = 9'b000000100,
    ST_D1_GO   = 9'b000001000,
    ST_D1_WAIT = 9'b000010000,
    ST_D2_GO   = 9'b000100000,
    ST_D2_WAIT = 9'b001000000,
    ST_SCALE   = 9'b010000000,
    ST_FINISH  = 9'b100000000
  } state_e;

  state_e                 state_q, state_d;
  logic [WW-1:0]          m_q, m_d;
  logic signed [5:0]      n_q, n_d;
  logic [DW-1:0]          y_q, y_d;
  logic [DW-1:0]          z_q, z_d;
  logic                   out_valid_q, out_valid_d;
  logic [RW-1:0]          root_q, root_d;

  logic [nsq_pkg::CONST_W-1:0] mul_a;
  logic [DW-1:0]               mul_b;
  logic [PW-1:0]               prod;
  logic signed [5:0]           half;
  logic [5:0]                  neg_half;
  logic [RW-1:0]               y_wide;
  logic [RW-1:0]               scaled;
  logic                        out_free;

  logic                        div_start;
  logic [DW-1:0]               div_divisor;
  nsq_pkg::div_stat_t          div_stat;
  logic [nsq_pkg::QUO_W-1:0]   div_quo;

  // One multiplier serves both the seed and the 1/sqrt2 correction.
  always_comb begin
    if (state_q == ST_SEED) begin
      mul_a = nsq_pkg::SEED_B;
      mul_b = DW'(m_q[FW-1:0]);
    end else begin
      mul_a = nsq_pkg::INV_SQRT2;
      mul_b = y_q;
    end
  end
  assign prod = PW'(mul_a) * PW'(mul_b);

  assign div_start   = (state_q == ST_D1_GO) || (state_q == ST_D2_GO);
  assign div_divisor = (state_q == ST_D1_GO) ? y_q : z_q;

  nsq_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .mant_i    (m_q[FW-1:0]),
    .divisor_i (div_divisor),
    .stat_o    (div_stat),
    .quo_o     (div_quo)
  );

  // Final scaling by half the exponent; the exponent is even by this point.
  assign half     = n_q >>> 1;
  assign neg_half = 6'(-half);
  assign y_wide   = RW'(y_q);
  assign scaled   = half[5] ? (y_wide >> neg_half[3:0]) : (y_wide << half[2:0]);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    m_d         = m_q;
    n_d         = n_q;
    y_d         = y_q;
    z_d         = z_q;
    out_valid_d = out_valid_q;
    root_d      = root_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          m_d = operand_i;
          n_d = '0;
          if (operand_i[WW-1] || (operand_i == '0)) begin
            y_d     = '0;
            state_d = ST_FINISH;
          end else begin
            state_d = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        if (m_q[WW-1:FW] != '0) begin
          m_d = m_q >> 1;
          n_d = n_q + 6'sd1;
        end else if (!m_q[FW-1]) begin
          m_d = m_q << 1;
          n_d = n_q - 6'sd1;
        end else begin
          state_d = ST_SEED;
        end
      end
      ST_SEED: begin
        y_d     = DW'(nsq_pkg::SEED_A) + prod[PW-1:FW];
        state_d = ST_D1_GO;
      end
      ST_D1_GO: begin
        state_d = ST_D1_WAIT;
      end
      ST_D1_WAIT: begin
        if (div_stat.done) begin
          z_d     = y_q + DW'(div_quo);
          state_d = ST_D2_GO;
        end
      end
      ST_D2_GO: begin
        state_d = ST_D2_WAIT;
      end
      ST_D2_WAIT: begin
        if (div_stat.done) begin
          y_d     = (z_q >> 2) + DW'(div_quo);
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (n_q[0]) begin
          y_d = prod[PW-1:FW];
          n_d = n_q + 6'sd1;
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          root_d      = scaled;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    n_q    <= n_d;
    y_q    <= y_d;
    z_q    <= z_d;
    root_q <= root_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign root_o      = root_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_D1_WAIT || state_q == ST_D2_WAIT))
    else $error("divider finished outside a wait step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEED) |-> (m_q[WW-1:FW-1] == 9'd1))
    else $error("mantissa not normalized at seed step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |-> !n_q[0])
    else $error("odd exponent reached final scaling");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_valid_q && !out_ready_i) |=> (state_q == ST_FINISH))
    else $error("result left final step while output register was full");
`endif

endmodule

// ----- verif/nsq_root_checker.sv -----
`timescale 1ns / 1ps
// Checker for the fixed-point Newton square root core: predicts each root and
// compares it with the output channel. Depends on nsq_pkg.
module nsq_root_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic signed [nsq_pkg::WORD_W-1:0] operand_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [nsq_pkg::ROOT_W-1:0]        root_i,
  output int                                errors_o,
  output int                                pending_o
);

  typedef struct {
    logic signed [nsq_pkg::WORD_W-1:0] operand;
    logic [nsq_pkg::ROOT_W-1:0]        root;
  } root_req_t;

  root_req_t pending_roots[$];
  root_req_t oldest;
  int        mismatches = 0;

  assign errors_o = mismatches;

  // Normalize to [0.5, 1), seed linearly, refine twice, then undo the shift.
  function automatic logic [nsq_pkg::ROOT_W-1:0] expected_root(
    logic signed [nsq_pkg::WORD_W-1:0] operand
  );
    logic [63:0] mant;
    logic [63:0] guess;
    logic [63:0] refined;
    int          shift;
    if (operand <= 0) return '0;
    mant  = 64'(unsigned'(operand));
    shift = 0;
    while (mant[31:24] != 0) begin
      shift++;
      mant = mant >> 1;
    end
    while (mant[31:23] == 0) begin
      shift--;
      mant = mant << 1;
    end
    guess   = 64'(nsq_pkg::SEED_A) +
              ((64'(nsq_pkg::SEED_B) * mant) >> nsq_pkg::FRAC_W);
    refined = guess + (mant << nsq_pkg::FRAC_W) / guess;
    guess   = (refined >> 2) + (mant << nsq_pkg::FRAC_W) / refined;
    if ((shift & 1) != 0) begin
      shift++;
      guess = (64'(nsq_pkg::INV_SQRT2) * guess) >> nsq_pkg::FRAC_W;
    end
    if (shift >= 0) guess = guess << (shift / 2);
    else guess = guess >> ((-shift) / 2);
    return guess[nsq_pkg::ROOT_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $time, what);
    mismatches++;
  endtask

  // Results are checked against the queue as it stood before this edge, so a
  // request accepted at the same edge can never pair with the result.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_roots.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_roots.size() == 0) begin
          report_mismatch($sformatf("root %h with no request outstanding", root_i));
        end else begin
          oldest = pending_roots.pop_front();
          if (root_i !== oldest.root) begin
            report_mismatch($sformatf("operand %h: root %h, expected %h",
                                      oldest.operand, root_i, oldest.root));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pending_roots.push_back('{operand: operand_i, root: expected_root(operand_i)});
      end
      pending_o <= pending_roots.size();
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Top of the square root testbench: clock, reset, request stimulus, output
// stalls and the verdict. Depends on nsq_pkg, fixed_point_newton_sqrt_core and nsq_root_checker.
module tb;

  localparam int CycleLimit  = 400000;
  localparam int RandomItems = 500;
  localparam int DrainCycles = 150;

  logic                              clk_i       = 1'b0;
  logic                              rst_ni      = 1'b0;
  logic                              in_valid_i  = 1'b0;
  logic                              in_ready_o;
  logic signed [nsq_pkg::WORD_W-1:0] operand_i   = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic [nsq_pkg::ROOT_W-1:0]        root_o;

  int errors;
  int pending;
  int cycles    = 0;
  int burst_left = 0;

  always #5 clk_i = ~clk_i;

  fixed_point_newton_sqrt_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .operand_i  (operand_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .root_o     (root_o)
  );

  nsq_root_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .operand_i  (operand_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .root_i     (root_o),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // The receiver rotates through steady, random, sparse and periodic stalls.
  always @(posedge clk_i) begin
    case ((cycles / 256) % 4)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= ($urandom_range(0, 7) == 0);
      default: out_ready_i <= ((cycles % 32) < 20);
    endcase
  end

  // Any idle time comes before the request, so valid is only lowered in a
  // step where it is not raised again.
  task automatic send_operand(input logic signed [nsq_pkg::WORD_W-1:0] value,
                              input bit drain);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
    end
    burst_left--;
    if (drain || gap > 0) begin
      in_valid_i <= 1'b0;
      if (drain) begin
        do @(negedge clk_i); while (pending != 0);
        @(posedge clk_i);
      end else begin
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    operand_i  <= value;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  // Mostly positive values with a random leading bit, so every shift count of
  // the normalizer shows up, plus zero, negatives and raw words.
  function automatic logic signed [nsq_pkg::WORD_W-1:0] random_operand();
    int unsigned lead;
    logic [nsq_pkg::WORD_W-1:0] word;
    case ($urandom_range(0, 9))
      0: word = '0;
      1, 2: word = $urandom;
      9: begin
        word = $urandom_range(1, 1 << 20);
        word = -word;
      end
      default: begin
        lead = $urandom_range(0, 30);
        word = $urandom;
        word = (word & ((32'h1 << lead) - 1)) | (32'h1 << lead);
      end
    endcase
    return word;
  endfunction

  initial begin
    logic signed [nsq_pkg::WORD_W-1:0] directed[$];
    directed = '{32'sh0, -32'sh1, 32'sh8000_0000, 32'sh8000_0001, -32'sd12345,
                 32'sh1, 32'sh2, 32'sh3, 32'sh7FFF_FFFF, 32'sh4000_0000,
                 32'sh7F00_0000, 32'sh0100_0000, 32'sh0080_0000, 32'sh00FF_FFFF,
                 32'sh0080_0001, 32'sh0200_0000, 32'sh0400_0000, 32'sh0000_0100,
                 32'sh0000_8000, 32'sh5555_5555, 32'sh2AAA_AAAA, 32'sh0123_4567};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_operand(directed[i], 1'b0);
    for (int i = 0; i < RandomItems; i++) begin
      send_operand(random_operand(), (i == 0) || (i == RandomItems / 2));
    end
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/nsq_pkg.sv
rtl/core/nsq_div.sv
rtl/core/fixed_point_newton_sqrt_core.sv
verif/nsq_root_checker.sv
verif/tb.sv
